// File: src/psubl_pkg.sv
package psubl_pkg;

  // Stream payload widths; the tdata widths are padded to whole bytes.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 160;

  // Largest intensity percent.
  localparam logic [6:0] MaxPercent = 7'd100;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ActSupervise    = 2'd0,
    ActSetFlag      = 2'd1,
    ActSetIntensity = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgTimeout = 2'd0,
    CfgForced  = 2'd1,
    CfgPeriod  = 2'd2
  } cfg_idx_e;

  // Snapshot of the supervisor state after one request.
  typedef struct packed {
    logic        supply_on;
    logic        relay_on;
    logic        relay_changed;
    logic [6:0]  current_intensity;
    logic [6:0]  applied_intensity;
    logic        duty_changed;
    logic [31:0] on_count;
    logic [31:0] off_count;
    logic [31:0] force_count;
    logic [31:0] change_count;
  } res_t;

endpackage

// File: src/psubl_state.sv
module psubl_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  psubl_pkg::action_e  action_i,
  input  logic                supply_pin_n_i,
  input  logic [31:0]         now_ms_i,
  input  logic [7:0]          host_value_i,
  input  logic [31:0]         timeout_ms_i,
  input  logic [6:0]          forced_intensity_i,
  output psubl_pkg::res_t     res_o
);
  import psubl_pkg::*;

  logic        supply_prev_q, supply_prev_d;
  logic [31:0] on_stamp_q, on_stamp_d;
  logic        flag_q, flag_d;
  logic        flag_prev_q, flag_prev_d;
  logic [6:0]  intensity_q, intensity_d;
  logic [6:0]  intensity_prev_q, intensity_prev_d;
  logic [31:0] on_count_q, on_count_d;
  logic [31:0] off_count_q, off_count_d;
  logic [31:0] force_count_q, force_count_d;
  logic [31:0] change_count_q, change_count_d;
  logic        relay_chg;
  logic        duty_chg;

  // Next state for one request.
  always_comb begin
    logic        supply;
    logic [31:0] elapsed;
    supply           = ~supply_pin_n_i;
    supply_prev_d    = supply_prev_q;
    on_stamp_d       = on_stamp_q;
    flag_d           = flag_q;
    flag_prev_d      = flag_prev_q;
    intensity_d      = intensity_q;
    intensity_prev_d = intensity_prev_q;
    on_count_d       = on_count_q;
    off_count_d      = off_count_q;
    force_count_d    = force_count_q;
    change_count_d   = change_count_q;
    relay_chg        = 1'b0;
    duty_chg         = 1'b0;
    elapsed          = '0;

    case (action_i)
      ActSupervise: begin
        // Supply edges stamp the time or shut the backlight down.
        if (supply != supply_prev_q) begin
          if (supply) begin
            on_stamp_d = now_ms_i;
            on_count_d = on_count_q + 32'd1;
          end else begin
            on_stamp_d  = '0;
            off_count_d = off_count_q + 32'd1;
            flag_d      = 1'b0;
            intensity_d = '0;
          end
          supply_prev_d = supply;
        end
        // Force the backlight on after the supply has been up long enough.
        elapsed = now_ms_i - on_stamp_d;
        if (supply && (elapsed > timeout_ms_i)) begin
          if (!flag_d) begin
            flag_d        = 1'b1;
            intensity_d   = (forced_intensity_i > MaxPercent) ? MaxPercent
                                                              : forced_intensity_i;
            force_count_d = force_count_q + 32'd1;
          end else begin
            on_stamp_d = '0;
          end
        end
        // Apply relay and duty only when they differ from what was applied.
        if (flag_d != flag_prev_q) begin
          flag_prev_d = flag_d;
          relay_chg   = 1'b1;
        end
        if (intensity_d != intensity_prev_q) begin
          intensity_prev_d = intensity_d;
          change_count_d   = change_count_q + 32'd1;
          duty_chg         = 1'b1;
        end
      end
      ActSetFlag: begin
        flag_d = (host_value_i != 8'd0);
      end
      ActSetIntensity: begin
        intensity_d = (host_value_i > {1'b0, MaxPercent}) ? MaxPercent
                                                          : host_value_i[6:0];
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_prev_q    <= 1'b0;
      on_stamp_q       <= '0;
      flag_q           <= 1'b0;
      flag_prev_q      <= 1'b0;
      intensity_q      <= '0;
      intensity_prev_q <= '0;
      on_count_q       <= '0;
      off_count_q      <= '0;
      force_count_q    <= '0;
      change_count_q   <= '0;
    end else if (accept_i) begin
      supply_prev_q    <= supply_prev_d;
      on_stamp_q       <= on_stamp_d;
      flag_q           <= flag_d;
      flag_prev_q      <= flag_prev_d;
      intensity_q      <= intensity_d;
      intensity_prev_q <= intensity_prev_d;
      on_count_q       <= on_count_d;
      off_count_q      <= off_count_d;
      force_count_q    <= force_count_d;
      change_count_q   <= change_count_d;
    end
  end

  // The result reflects the state as this request leaves it.
  always_comb begin
    res_o.supply_on         = supply_prev_d;
    res_o.relay_on          = flag_prev_d;
    res_o.relay_changed     = relay_chg;
    res_o.current_intensity = intensity_d;
    res_o.applied_intensity = intensity_prev_d;
    res_o.duty_changed      = duty_chg;
    res_o.on_count          = on_count_d;
    res_o.off_count         = off_count_d;
    res_o.force_count       = force_count_d;
    res_o.change_count      = change_count_d;
  end

endmodule

// File: src/psu_backlight_supervisor.sv
// Supply and backlight supervisor. Each input request is either a supervise
// step (supply pin and millisecond time), a host write of the backlight on
// flag, or a host write of the intensity; every request yields exactly one
// result with the decoded supply state, the applied relay level, the
// intensity, the PWM compare value (pwm_period * applied intensity / 100) and
// four wrapping event counters. One request is taken per clock cycle while the
// result stream does not stall; stage one registers the state snapshot and the
// product, and stage two registers the result after the constant divide. The
// configuration registers reset to timeout 10000 ms, forced intensity 50 and
// period 480, and should only be written while no request is in flight.
module psu_backlight_supervisor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, from bit 0: supply_pin_n, now_ms[31:0], host_value[7:0], zero pad.
  input  logic [psubl_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: action[1:0].
  input  logic [psubl_pkg::InUserW-1:0]    s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, from bit 0: supply_on, relay_on, relay_changed,
  // current_intensity[6:0], compare_value[15:0], duty_changed,
  // supply_on_events, supply_off_events, forced_on_events,
  // duty_change_events (32 bits each), zero pad.
  output logic [psubl_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_addr_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import psubl_pkg::*;

  // x / 100 is taken as (x >> 2) / 25, with a reciprocal exact below 2^21.
  localparam int unsigned RecipShift = 26;
  localparam logic [21:0] RecipMul   = 22'd2684355;

  logic [31:0] timeout_q;
  logic [6:0]  forced_q;
  logic [15:0] period_q;

  logic        out_ready;
  logic        s1_ready;
  logic        in_accept;
  res_t        res_d;
  logic [22:0] prod_d;

  logic        s1_valid_q;
  res_t        s1_res_q;
  logic [22:0] s1_prod_q;

  logic [42:0] recip_prod;
  logic [15:0] cmp_d;

  logic        out_valid_q;
  res_t        out_res_q;
  logic [15:0] out_cmp_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd10000;
      forced_q  <= 7'd50;
      period_q  <= 16'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgTimeout: timeout_q <= cfg_wdata_i;
        CfgForced:  forced_q  <= cfg_wdata_i[6:0];
        CfgPeriod:  period_q  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control: each stage advances when the one after it frees.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_accept     = s_axis_tvalid && s1_ready;

  psubl_state u_state (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .action_i           (action_e'(s_axis_tuser)),
    .supply_pin_n_i     (s_axis_tdata[0]),
    .now_ms_i           (s_axis_tdata[32:1]),
    .host_value_i       (s_axis_tdata[40:33]),
    .timeout_ms_i       (timeout_q),
    .forced_intensity_i (forced_q),
    .res_o              (res_d)
  );

  // Period times applied intensity; fits 23 bits since intensity is at most 100.
  assign prod_d = {7'd0, period_q} * {16'd0, res_d.applied_intensity};

  // Stage one: state snapshot and product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q  <= res_d;
      s1_prod_q <= prod_d;
    end
  end

  // Divide the product by 100.
  assign recip_prod = {22'd0, s1_prod_q[22:2]} * {21'd0, RecipMul};
  assign cmp_d      = recip_prod[RecipShift +: 16];

  // Stage two: result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_res_q <= s1_res_q;
      out_cmp_q <= cmp_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          out_res_q.change_count,
                          out_res_q.force_count,
                          out_res_q.off_count,
                          out_res_q.on_count,
                          out_res_q.duty_changed,
                          out_cmp_q,
                          out_res_q.current_intensity,
                          out_res_q.relay_changed,
                          out_res_q.relay_on,
                          out_res_q.supply_on};

endmodule
